[rtl/bxavg_pkg.sv]
// ----------------------------------------------------------------------------
// bxavg_pkg
// Shared types, sizes and the reciprocal table of the box average downscaler.
// ----------------------------------------------------------------------------
package bxavg_pkg;

	localparam int MAX_DEST_WIDTH = 1024;
	localparam int COL_W          = (MAX_DEST_WIDTH > 1) ? $clog2(MAX_DEST_WIDTH) : 1;
	localparam int DEST_COL_W     = 10;
	localparam int FACTOR_W       = 5;
	localparam int WIDTH_W        = 11;
	localparam int CNT_W          = 4;
	localparam int LANES          = 4;
	localparam int BYTE_W         = 8;
	localparam int SUM_W          = 16;
	localparam int RECIP_W        = 23;
	localparam int RECIP_SHIFT    = 24;
	localparam int FACTOR_MIN     = 2;
	localparam int FACTOR_MAX     = 16;

	typedef enum logic [0:0] {
		CFG_SCALE_FACTOR = 1'b0,
		CFG_DEST_WIDTH   = 1'b1
	} cfg_idx_t;

	typedef logic [LANES-1:0][BYTE_W-1:0] byte_lanes_t;
	typedef logic [LANES-1:0][SUM_W-1:0]  sum_lanes_t;

	typedef struct packed {
		sum_lanes_t       sums;
		logic [COL_W-1:0] col;
		logic             row_end;
	} emit_t;

	// ceil(2^24 / (n*n)); exact floor quotient for any 16-bit sum
	function automatic logic [RECIP_W-1:0] recip_of(input logic [FACTOR_W-1:0] n);
		logic [RECIP_W-1:0] r;
		unique case (n)
			5'd3:    r = RECIP_W'(1864136);
			5'd4:    r = RECIP_W'(1048576);
			5'd5:    r = RECIP_W'(671089);
			5'd6:    r = RECIP_W'(466034);
			5'd7:    r = RECIP_W'(342393);
			5'd8:    r = RECIP_W'(262144);
			5'd9:    r = RECIP_W'(207127);
			5'd10:   r = RECIP_W'(167773);
			5'd11:   r = RECIP_W'(138655);
			5'd12:   r = RECIP_W'(116509);
			5'd13:   r = RECIP_W'(99274);
			5'd14:   r = RECIP_W'(85599);
			5'd15:   r = RECIP_W'(74566);
			5'd16:   r = RECIP_W'(65536);
			default: r = RECIP_W'(4194304);
		endcase
		return r;
	endfunction

endpackage

[rtl/box_average_downscaler_top.sv]
// ----------------------------------------------------------------------------
// box_average_downscaler_top
// Integer box-filter downscale: N-by-N block averages of a raster pixel stream.
// ----------------------------------------------------------------------------
//  channel | signals                                   | transfer
//  --------+-------------------------------------------+---------------------
//  cfg     | cfg_we, cfg_index, cfg_data               | write when cfg_we
//  in      | in_valid, in_ready, pixel_byte0..3        | valid & ready
//  out     | out_valid, out_ready, avg_byte0..3,       | valid & ready
//          | dest_column, row_end                      |
//
//  One source pixel per cycle while in_ready is high; a result passes stage 1,
//  stage 2 and the output register after the last pixel of its block. The
//  accumulator memory's read-modify-write with forwarding sets the rate. After
//  reset and every register write, clearing all MAX_DEST_WIDTH (1024) columns
//  holds in_ready low. A stalled result fills two stages before in_ready drops.
// ----------------------------------------------------------------------------
module box_average_downscaler_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  bxavg_pkg::cfg_idx_t              cfg_index,
	input  logic [bxavg_pkg::WIDTH_W-1:0]    cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [7:0]                       pixel_byte0,
	input  logic [7:0]                       pixel_byte1,
	input  logic [7:0]                       pixel_byte2,
	input  logic [7:0]                       pixel_byte3,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [7:0]                       avg_byte0,
	output logic [7:0]                       avg_byte1,
	output logic [7:0]                       avg_byte2,
	output logic [7:0]                       avg_byte3,
	output logic [bxavg_pkg::DEST_COL_W-1:0] dest_column,
	output logic                             row_end
);
	import bxavg_pkg::*;

	logic [FACTOR_W-1:0] scale_q;
	logic [WIDTH_W-1:0]  width_q;
	logic [CNT_W-1:0]    group_q;
	logic [CNT_W-1:0]    row_q;
	logic [COL_W-1:0]    col_q;

	logic [FACTOR_W-1:0] n_eff;
	logic [CNT_W-1:0]    n_last;
	logic [COL_W-1:0]    w_last;
	logic                accept;
	logic                group_last;
	logic                emit;
	logic                col_last;
	byte_lanes_t         pix;
	byte_lanes_t         avg;
	logic                emit_valid;
	logic                emit_ready;
	emit_t               emit_data;

	always_comb begin
		if (scale_q < FACTOR_W'(FACTOR_MIN)) begin
			n_eff = FACTOR_W'(FACTOR_MIN);
		end else if (scale_q > FACTOR_W'(FACTOR_MAX)) begin
			n_eff = FACTOR_W'(FACTOR_MAX);
		end else begin
			n_eff = scale_q;
		end
		n_last = CNT_W'(n_eff - 1'b1);
		if (32'(width_q) > MAX_DEST_WIDTH) begin
			w_last = COL_W'(MAX_DEST_WIDTH - 1);
		end else if (width_q == '0) begin
			w_last = '0;
		end else begin
			w_last = COL_W'(width_q - 1'b1);
		end
	end

	assign accept     = in_valid && in_ready;
	assign group_last = (group_q == n_last);
	assign col_last   = (col_q == w_last);
	assign emit       = group_last && (row_q == n_last);
	assign pix        = {pixel_byte3, pixel_byte2, pixel_byte1, pixel_byte0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= FACTOR_W'(FACTOR_MIN);
			width_q <= WIDTH_W'(1024);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SCALE_FACTOR: scale_q <= cfg_data[FACTOR_W-1:0];
				CFG_DEST_WIDTH:   width_q <= cfg_data;
				default:          scale_q <= scale_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_q <= '0;
			row_q   <= '0;
			col_q   <= '0;
		end else if (cfg_we) begin
			group_q <= '0;
			row_q   <= '0;
			col_q   <= '0;
		end else if (accept) begin
			if (group_last) begin
				group_q <= '0;
				if (col_last) begin
					col_q <= '0;
					row_q <= (row_q == n_last) ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end else begin
				group_q <= group_q + 1'b1;
			end
		end
	end

	bxavg_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (cfg_we),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pix        (pix),
		.col        (col_q),
		.emit       (emit),
		.row_end    (col_last),
		.emit_valid (emit_valid),
		.emit_ready (emit_ready),
		.emit_data  (emit_data)
	);

	bxavg_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.factor     (n_eff),
		.emit_valid (emit_valid),
		.emit_ready (emit_ready),
		.emit_data  (emit_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.avg        (avg),
		.col        (dest_column),
		.row_end    (row_end)
	);

	assign avg_byte0 = avg[0];
	assign avg_byte1 = avg[1];
	assign avg_byte2 = avg[2];
	assign avg_byte3 = avg[3];

endmodule

[rtl/bxavg_accum.sv]
// ----------------------------------------------------------------------------
// bxavg_accum
// Column accumulator memory with read-modify-write, forwarding and clear pass.
// ----------------------------------------------------------------------------
module bxavg_accum (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        restart,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  bxavg_pkg::byte_lanes_t      pix,
	input  logic [bxavg_pkg::COL_W-1:0] col,
	input  logic                        emit,
	input  logic                        row_end,
	output logic                        emit_valid,
	input  logic                        emit_ready,
	output bxavg_pkg::emit_t            emit_data
);
	import bxavg_pkg::*;

	sum_lanes_t       mem [MAX_DEST_WIDTH];

	logic             clr_busy_q;
	logic [COL_W-1:0] clr_cnt_q;

	logic             valid_s1;
	byte_lanes_t      pix_s1;
	logic [COL_W-1:0] col_s1;
	logic             emit_s1;
	logic             row_end_s1;
	sum_lanes_t       rdata_s1;

	logic             fwd_valid_q;
	logic [COL_W-1:0] fwd_col_q;
	sum_lanes_t       fwd_sum_q;

	logic             accept;
	logic             s1_go;
	sum_lanes_t       base;
	sum_lanes_t       sum;
	sum_lanes_t       wdata;
	logic             we;
	logic [COL_W-1:0] waddr;

	assign s1_go    = valid_s1 && (!emit_s1 || emit_ready);
	assign in_ready = !clr_busy_q && (!valid_s1 || s1_go);
	assign accept   = in_valid && in_ready;

	always_comb begin
		base = (fwd_valid_q && (fwd_col_q == col_s1)) ? fwd_sum_q : rdata_s1;
		for (int l = 0; l < LANES; l++) begin
			sum[l] = base[l] + SUM_W'(pix_s1[l]);
		end
		if (clr_busy_q) begin
			we    = 1'b1;
			waddr = clr_cnt_q;
			wdata = '0;
		end else begin
			we    = s1_go;
			waddr = col_s1;
			wdata = emit_s1 ? '0 : sum;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rdata_s1   <= mem[col];
			pix_s1     <= pix;
			col_s1     <= col;
			emit_s1    <= emit;
			row_end_s1 <= row_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (restart) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			if (clr_cnt_q == COL_W'(MAX_DEST_WIDTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else if (restart || clr_busy_q) begin
			valid_s1    <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			if (s1_go) begin
				fwd_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			fwd_col_q <= col_s1;
			fwd_sum_q <= wdata;
		end
	end

	assign emit_valid        = valid_s1 && emit_s1;
	assign emit_data.sums    = sum;
	assign emit_data.col     = col_s1;
	assign emit_data.row_end = row_end_s1;

endmodule

[rtl/bxavg_div.sv]
// ----------------------------------------------------------------------------
// bxavg_div
// Block sum to average by reciprocal multiply, with the output register.
// ----------------------------------------------------------------------------
module bxavg_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [bxavg_pkg::FACTOR_W-1:0]   factor,
	input  logic                             emit_valid,
	output logic                             emit_ready,
	input  bxavg_pkg::emit_t                 emit_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output bxavg_pkg::byte_lanes_t           avg,
	output logic [bxavg_pkg::DEST_COL_W-1:0] col,
	output logic                             row_end
);
	import bxavg_pkg::*;

	localparam int PROD_W = SUM_W + RECIP_W;

	logic [RECIP_W-1:0]    recip_q;
	logic                  valid_s2;
	emit_t                 data_s2;
	logic                  out_valid_q;
	byte_lanes_t           avg_q;
	logic [DEST_COL_W-1:0] col_q;
	logic                  row_end_q;

	logic                  out_go;
	logic                  s2_go;
	logic [PROD_W-1:0]     prod [LANES];
	byte_lanes_t           quo;

	assign out_go     = !out_valid_q || out_ready;
	assign s2_go      = valid_s2 && out_go;
	assign emit_ready = !valid_s2 || s2_go;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			prod[l] = PROD_W'(data_s2.sums[l]) * PROD_W'(recip_q);
			quo[l]  = prod[l][RECIP_SHIFT +: BYTE_W];
		end
	end

	always_ff @(posedge clk) begin
		recip_q <= recip_of(factor);
		if (emit_valid && emit_ready) begin
			data_s2 <= emit_data;
		end
		if (s2_go) begin
			avg_q     <= quo;
			col_q     <= DEST_COL_W'(data_s2.col);
			row_end_q <= data_s2.row_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_valid && emit_ready) begin
				valid_s2 <= 1'b1;
			end else if (s2_go) begin
				valid_s2 <= 1'b0;
			end
			if (s2_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign avg       = avg_q;
	assign col       = col_q;
	assign row_end   = row_end_q;

endmodule

[rtl/bxavg_checker.sv]
// ----------------------------------------------------------------------------
// bxavg_checker
// Port-level checks of the downscaler, bound to the top level.
// ----------------------------------------------------------------------------
module bxavg_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             cfg_we,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic [7:0]                       pixel_byte0,
	input logic [7:0]                       pixel_byte1,
	input logic [7:0]                       pixel_byte2,
	input logic [7:0]                       pixel_byte3,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [7:0]                       avg_byte0,
	input logic [7:0]                       avg_byte1,
	input logic [7:0]                       avg_byte2,
	input logic [7:0]                       avg_byte3,
	input logic [bxavg_pkg::DEST_COL_W-1:0] dest_column,
	input logic                             row_end
);

	// waiting input request holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(pixel_byte0) && $stable(pixel_byte1)
			&& $stable(pixel_byte2) && $stable(pixel_byte3))
		else $error("waiting input request changed");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(avg_byte0) && $stable(avg_byte1)
			&& $stable(avg_byte2) && $stable(avg_byte3) && $stable(dest_column)
			&& $stable(row_end))
		else $error("stalled result changed");

	// register write starts the clearing pass
	a_cfg_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !in_ready)
		else $error("input taken during clearing pass");

	// outside a clearing pass, input stalls only behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) && !$past(cfg_we) |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

endmodule

bind box_average_downscaler_top bxavg_checker u_bxavg_checker (.*);
